>>> hdl/glut_pkg.sv
`timescale 1ns / 1ps

package glut_pkg;

    localparam int LUT_SIZE  = 256;
    localparam int MAX_STOPS = 16;
    localparam int DBITS     = $clog2(LUT_SIZE);
    localparam int LUT_D     = LUT_SIZE - 1;
    localparam int SBITS     = $clog2(MAX_STOPS);
    localparam int HALF_D    = LUT_D / 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_STOP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_LAYER_COUNT = 2'd1;
    localparam logic [1:0] CFG_MIRROR_MODE = 2'd2;

    typedef struct packed {
        logic mul_en;
        logic out_en;
    } glut_blend_ctl_t;

    // quotient by LUT_D = 2^DBITS - 1, exact while the quotient stays below 2^DBITS
    function automatic logic [DBITS-1:0] div_d(input logic [2*DBITS:0] x);
        logic [2*DBITS:0] t;
        t = x + (2*DBITS+1)'(1) + (x >> DBITS);
        return t[2*DBITS-1:DBITS];
    endfunction

endpackage

>>> hdl/glut_blend.sv
`timescale 1ns / 1ps

module glut_blend (
    input  logic                   aclk,
    input  glut_pkg::glut_blend_ctl_t ctl,
    input  logic [7:0]             a,
    input  logic [7:0]             b,
    input  logic [glut_pkg::DBITS-1:0] r,
    output logic [7:0]             y
);
    import glut_pkg::*;

    logic [2*DBITS-1:0] mix_reg, mix_next;
    logic [7:0]         y_reg, y_next;
    logic [DBITS-1:0]   rc;

    always_comb begin
        rc       = DBITS'(LUT_D) - r;
        mix_next = (2*DBITS)'(a * rc) + (2*DBITS)'(b * r);
        // round to nearest, ties up
        y_next   = 8'(div_d({1'b0, mix_reg} + (2*DBITS+1)'(HALF_D)));
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            mix_reg <= mix_next;
        end
        if (ctl.out_en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

>>> hdl/gradient_lut_sampler_core.sv
`timescale 1ns / 1ps
// gradient_lut_sampler_core
// Input channel (s_*): one beat per item. op = write stores one colour stop
// and gives no result; op = sample returns the gradient colour at lut_index.
// Result channel (m_*): red, green, blue of each sample beat, in order.
// Configuration channel (cfg_*): stop_count, layer_count, mirror_mode,
// written by index; cfg_ready is always high. Write only while idle.
// A sample accepted into stage 1 shows on m_valid once it reaches stage 8.
// Throughput: one beat per cycle while the receiver keeps up, set by an 8-stage
// pipeline in which multiplies and divisions by LUT_SIZE-1 sit in separate stages.
// Stop writes travel down the pipeline and update the stop store at the
// stage where samples read it, so order of writes and samples is kept.
// Reset clears all stage valid bits and restores the register defaults;
// the stop store is undefined until written.
// When the receiver stalls, the output holds and empty stages ahead of it
// keep filling; s_ready falls only when all stages are occupied.
module gradient_lut_sampler_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [3:0] s_stop_index,
    input  logic [7:0] s_stop_red,
    input  logic [7:0] s_stop_green,
    input  logic [7:0] s_stop_blue,
    input  logic [7:0] s_lut_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import glut_pkg::*;

    // configuration
    logic [4:0] stop_count_reg;
    logic [7:0] layer_count_reg;
    logic       mirror_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg  <= 5'd2;
            layer_count_reg <= 8'd1;
            mirror_reg      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STOP_COUNT:  stop_count_reg  <= cfg_data[4:0];
                CFG_LAYER_COUNT: layer_count_reg <= cfg_data;
                CFG_MIRROR_MODE: mirror_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [7:0]       layers;
    logic [SBITS-1:0] nm1;

    always_comb begin
        layers = (layer_count_reg == 8'd0) ? 8'd1 : layer_count_reg;
        if (stop_count_reg == 5'd0) begin
            nm1 = '0;
        end else if (32'(stop_count_reg) > MAX_STOPS) begin
            nm1 = SBITS'(MAX_STOPS - 1);
        end else begin
            nm1 = SBITS'(stop_count_reg - 5'd1);
        end
    end

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

    assign rdy8    = !v8_reg || m_ready;
    assign rdy7    = !v7_reg || rdy8;
    assign rdy6    = !v6_reg || rdy7;
    assign rdy5    = !v5_reg || rdy6;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // payload carried through the front stages
    logic             op1_reg, op2_reg, op3_reg, op4_reg, op5_reg;
    logic [SBITS-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [23:0]      col1_reg, col2_reg, col3_reg, col4_reg, col5_reg;
    logic [7:0]       i1_reg;
    logic [2*DBITS-1:0] prod2_reg, prod2_next;
    logic [DBITS-1:0] fn3_reg, fn3_next;
    logic [DBITS+SBITS-1:0] p4_reg, p4_next;
    logic [SBITS-1:0] k5_reg, k5_next;
    logic [DBITS-1:0] r5_reg, r5_next;
    logic [23:0]      c0_reg, c1_reg;
    logic [DBITS-1:0] r6_reg;

    logic [DBITS-1:0]   q3, rem3, layer3;
    logic [2*DBITS:0]   rem3_w;
    logic [SBITS-1:0]   kq5;
    logic [DBITS+SBITS:0] r5_w;

    always_comb begin
        prod2_next = (2*DBITS)'(i1_reg * layers);

        q3     = div_d({1'b0, prod2_reg});
        rem3_w = {1'b0, prod2_reg} - {1'b0, q3, {DBITS{1'b0}}} + (2*DBITS+1)'(q3);
        rem3   = rem3_w[DBITS-1:0];
        if (q3 >= layers) begin
            layer3   = layers - 8'd1;
            fn3_next = DBITS'(LUT_D);
        end else begin
            layer3   = q3;
            fn3_next = rem3;
        end
        if (mirror_reg && layer3[0]) begin
            fn3_next = DBITS'(LUT_D) - fn3_next;
        end

        p4_next = (DBITS+SBITS)'(fn3_reg * nm1);

        kq5 = SBITS'(div_d((2*DBITS+1)'(p4_reg)));
        if (nm1 == '0) begin
            k5_next = '0;
        end else if (kq5 > nm1 - SBITS'(1)) begin
            k5_next = nm1 - SBITS'(1);
        end else begin
            k5_next = kq5;
        end
        r5_w    = {1'b0, p4_reg} - (DBITS+SBITS+1)'({k5_next, {DBITS{1'b0}}})
                + (DBITS+SBITS+1)'(k5_next);
        r5_next = r5_w[DBITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg && (op5_reg == OP_SAMPLE);
            if (rdy7) v7_reg <= v6_reg;
            if (rdy8) v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            op1_reg  <= s_op;
            idx1_reg <= s_stop_index;
            col1_reg <= {s_stop_red, s_stop_green, s_stop_blue};
            i1_reg   <= s_lut_index;
        end
        if (rdy2) begin
            op2_reg   <= op1_reg;
            idx2_reg  <= idx1_reg;
            col2_reg  <= col1_reg;
            prod2_reg <= prod2_next;
        end
        if (rdy3) begin
            op3_reg  <= op2_reg;
            idx3_reg <= idx2_reg;
            col3_reg <= col2_reg;
            fn3_reg  <= fn3_next;
        end
        if (rdy4) begin
            op4_reg  <= op3_reg;
            idx4_reg <= idx3_reg;
            col4_reg <= col3_reg;
            p4_reg   <= p4_next;
        end
        if (rdy5) begin
            op5_reg  <= op4_reg;
            idx5_reg <= idx4_reg;
            col5_reg <= col4_reg;
            k5_reg   <= k5_next;
            r5_reg   <= r5_next;
        end
    end

    // colour stop store
    logic [23:0] stop_mem [MAX_STOPS];

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            if (v5_reg && (op5_reg == OP_WRITE)) begin
                stop_mem[idx5_reg] <= col5_reg;
            end
            c0_reg <= stop_mem[k5_reg];
            // a single stop never touches the next entry
            c1_reg <= stop_mem[(nm1 == '0) ? k5_reg : k5_reg + SBITS'(1)];
            r6_reg <= r5_reg;
        end
    end

    glut_blend_ctl_t bctl;

    assign bctl.mul_en = rdy7;
    assign bctl.out_en = rdy8;

    glut_blend u_blend_r (
        .aclk (aclk),
        .ctl  (bctl),
        .a    (c0_reg[23:16]),
        .b    (c1_reg[23:16]),
        .r    (r6_reg),
        .y    (m_red)
    );

    glut_blend u_blend_g (
        .aclk (aclk),
        .ctl  (bctl),
        .a    (c0_reg[15:8]),
        .b    (c1_reg[15:8]),
        .r    (r6_reg),
        .y    (m_green)
    );

    glut_blend u_blend_b (
        .aclk (aclk),
        .ctl  (bctl),
        .a    (c0_reg[7:0]),
        .b    (c1_reg[7:0]),
        .r    (r6_reg),
        .y    (m_blue)
    );

    assign m_valid = v8_reg;

    // input blocks only with the receiver stalled and stages 1, 4, 7 and 8 full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v4_reg && v7_reg && m_valid && !m_ready))
        else $error("s_ready low with a free stage");

    // segment index stays inside the stops in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && (op5_reg == OP_SAMPLE) |->
            ((nm1 == '0) ? (k5_reg == '0) : (k5_reg < nm1)))
        else $error("segment index out of range");

    // interpolation weight never passes the full step
    assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && (op5_reg == OP_SAMPLE) |-> (32'(r5_reg) <= LUT_D))
        else $error("interpolation weight out of range");

    // a stalled result keeps its red and blue channels while the stages behind it advance
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_blue))
        else $error("stalled result changed");

endmodule

>>> test/gradient_lut_sampler_core_tb.sv
`timescale 1ns / 1ps

module gradient_lut_sampler_core_tb;
    import glut_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int N_PHASES     = 12;
    localparam int PHASE_ITEMS  = 107;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic       op;
        logic [3:0] idx;
        rgb_t       color;
        logic [7:0] pos;
        logic       known;
        rgb_t       want;
    } dir_row_t;

    // default settings after reset: two stops, one layer, no mirror
    localparam dir_row_t DIR_ROWS [24] = '{
        '{OP_WRITE,  4'd0,  24'hff0080, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd1,  24'h00ff7f, 8'd255, 1'b0, 24'h0},
        '{OP_WRITE,  4'd2,  24'h123456, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd3,  24'ha5c3e1, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd4,  24'hffffff, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd5,  24'h000000, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd6,  24'h80807f, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd7,  24'h0f1e2d, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd8,  24'hf0e1d2, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd9,  24'h3c5a78, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd10, 24'h9bd7ff, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd11, 24'h010203, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd12, 24'hfefdfc, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd13, 24'h55aa55, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd14, 24'haa55aa, 8'd0,   1'b0, 24'h0},
        '{OP_WRITE,  4'd15, 24'hc0ffee, 8'd0,   1'b0, 24'h0},
        '{OP_SAMPLE, 4'd15, 24'hffffff, 8'd0,   1'b1, 24'hff0080},
        '{OP_SAMPLE, 4'd0,  24'h000000, 8'd255, 1'b1, 24'h00ff7f},
        '{OP_SAMPLE, 4'd7,  24'h5a5a5a, 8'd128, 1'b0, 24'h0},
        '{OP_SAMPLE, 4'd8,  24'ha5a5a5, 8'd1,   1'b0, 24'h0},
        '{OP_SAMPLE, 4'd3,  24'h123456, 8'd127, 1'b0, 24'h0},
        '{OP_WRITE,  4'd0,  24'h000000, 8'd200, 1'b0, 24'h0},
        '{OP_SAMPLE, 4'd0,  24'h000000, 8'd0,   1'b1, 24'h000000},
        '{OP_SAMPLE, 4'd9,  24'hffffff, 8'd254, 1'b0, 24'h0}
    };

    // stop count, layer count, mirror per phase; later phases draw at random
    localparam logic [7:0] PHASE_CFG [8][3] = '{
        '{8'd1,  8'd1,   8'd0},
        '{8'd16, 8'd255, 8'd1},
        '{8'd0,  8'd0,   8'd1},
        '{8'd31, 8'd3,   8'd1},
        '{8'd17, 8'd128, 8'd0},
        '{8'd2,  8'd255, 8'd1},
        '{8'd8,  8'd2,   8'd1},
        '{8'd5,  8'd7,   8'd0}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_op = OP_WRITE;
    logic [3:0] s_stop_index = '0;
    logic [7:0] s_stop_red = '0;
    logic [7:0] s_stop_green = '0;
    logic [7:0] s_stop_blue = '0;
    logic [7:0] s_lut_index = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_STOP_COUNT;
    logic [7:0] cfg_data = '0;

    rgb_t       stop_palette [MAX_STOPS];
    logic [4:0] n_stops_reg = 5'd2;
    logic [7:0] layers_reg = 8'd1;
    logic       mirror_reg = 1'b0;
    rgb_t       pending_colors [$];
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;
    int         err_count = 0;
    int         cycles = 0;

    gradient_lut_sampler_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_stop_index (s_stop_index),
        .s_stop_red   (s_stop_red),
        .s_stop_green (s_stop_green),
        .s_stop_blue  (s_stop_blue),
        .s_lut_index  (s_lut_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] mix_channel(input int a, input int b, input int r);
        return 8'((2 * a * LUT_D + 2 * (b - a) * r + LUT_D) / (2 * LUT_D));
    endfunction

    function automatic rgb_t gradient_color(input logic [7:0] pos);
        int   n, lay, idx, prod, layer, fn, k, r;
        rgb_t lo, hi, res;
        n = n_stops_reg;
        if (n < 1) n = 1;
        if (n > MAX_STOPS) n = MAX_STOPS;
        lay = layers_reg;
        if (lay < 1) lay = 1;
        idx = pos;
        if (idx > LUT_D) idx = LUT_D;
        if (n == 1) return stop_palette[0];
        prod  = idx * lay;
        layer = prod / LUT_D;
        fn    = prod % LUT_D;
        // last index lands exactly on the end of the last layer
        if (layer >= lay) begin
            layer = lay - 1;
            fn    = LUT_D;
        end
        if (mirror_reg && (layer % 2 == 1)) fn = LUT_D - fn;
        k = fn * (n - 1) / LUT_D;
        if (k > n - 2) k = n - 2;
        r  = fn * (n - 1) - k * LUT_D;
        lo = stop_palette[k];
        hi = stop_palette[k + 1];
        res.red   = mix_channel(lo.red, hi.red, r);
        res.green = mix_channel(lo.green, hi.green, r);
        res.blue  = mix_channel(lo.blue, hi.blue, r);
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [3:0] idx, input rgb_t color,
                             input logic [7:0] pos, input logic known, input rgb_t want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_stop_index <= idx;
        s_stop_red   <= color.red;
        s_stop_green <= color.green;
        s_stop_blue  <= color.blue;
        s_lut_index  <= pos;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_WRITE) stop_palette[idx] = color;
        else pending_colors.push_back(known ? want : gradient_color(pos));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        // stop writes give no beat but may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STOP_COUNT:  n_stops_reg = data[4:0];
            CFG_LAYER_COUNT: layers_reg = data;
            CFG_MIRROR_MODE: mirror_reg = data[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    initial begin
        int         stall;
        rgb_t       want;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected beat %h %h %h", $time, m_red, m_green, m_blue);
                err_count++;
            end else begin
                want = pending_colors.pop_front();
                if (m_red !== want.red) begin
                    $display("%0t: red expected %h actual %h", $time, want.red, m_red);
                    err_count++;
                end
                if (m_green !== want.green) begin
                    $display("%0t: green expected %h actual %h", $time, want.green, m_green);
                    err_count++;
                end
                if (m_blue !== want.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue, m_blue);
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic       op;
        logic [7:0] pos;
        logic [7:0] sc, lc, mm;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[j]) begin
            send_item(DIR_ROWS[j].op, DIR_ROWS[j].idx, DIR_ROWS[j].color,
                      DIR_ROWS[j].pos, DIR_ROWS[j].known, DIR_ROWS[j].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            tx_idle = (ph % 4) != 1;
            rx_idle = (ph % 4) != 2;
            if (ph < 8) begin
                sc = PHASE_CFG[ph][0];
                lc = PHASE_CFG[ph][1];
                mm = PHASE_CFG[ph][2];
            end else begin
                sc = $urandom_range(0, 31);
                lc = $urandom_range(0, 255);
                mm = $urandom_range(0, 1);
            end
            // upper bits beyond the register width are don't-care
            cfg_write(CFG_STOP_COUNT, {3'($urandom), sc[4:0]});
            cfg_write(CFG_LAYER_COUNT, lc);
            cfg_write(CFG_MIRROR_MODE, {7'($urandom), mm[0]});
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                op = ($urandom_range(0, 3) != 0) ? OP_SAMPLE : OP_WRITE;
                if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 1) ? 8'hff : 8'h00;
                else pos = $urandom_range(0, 255);
                send_item(op, 4'($urandom_range(0, 15)), rgb_t'(24'($urandom)), pos,
                          1'b0, '0);
            end
        end

        drain_results();
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
